[src/olist_pkg.sv]
// olist_pkg: shared types, constants and codes for the ordered list engine
// used by olist_ctrl and ordered_list_engine_top; olist_ram stays generic
package olist_pkg;

  localparam int CAPACITY = 16;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // common width for comparing a 4-bit position against the count
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_READ   = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] rank;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         fpos;
    logic signed [31:0] id;
    logic signed [31:0] rank;
    logic [4:0]         length;
  } result_t;

endpackage

[src/olist_ram.sv]
// olist_ram: generic single write port, single registered read port memory
// no dependencies
module olist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/olist_ctrl.sv]
// olist_ctrl: sequencer that walks the entry memory one read per cycle for
// shift, search and fetch; depends on olist_pkg
module olist_ctrl import olist_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic signed [31:0] entry_id,
  input  logic signed [31:0] entry_rank,
  input  logic [3:0]        position,
  input  logic              slot_free,
  output logic              res_push,
  output result_t           res,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output entry_t            ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  entry_t            ram_rdata
);

  state_t             state, state_next;
  mode_t              req_mode;
  logic signed [31:0] req_id;
  logic signed [31:0] req_rank;
  logic [AW-1:0]      req_pos;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [CW-1:0]      left;
  logic               rd_vld;
  logic [AW-1:0]      rd_src;
  logic [AW-1:0]      wr_addr;
  logic [1:0]         res_status;
  logic [3:0]         res_fpos;
  logic signed [31:0] res_id;
  logic signed [31:0] res_rank;

  logic is_full;
  logic bad_pos;
  logic hit;
  logic accept;

  assign accept  = in_valid && in_ready;
  assign is_full = (count == CW'(CAPACITY));
  assign bad_pos = (PW'(position) >= PW'(count));
  assign hit     = rd_vld && (req_mode == MODE_SEARCH) && (ram_rdata.id == req_id);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(mode))
            MODE_APPEND: state_next = is_full ? S_DONE : S_WRITE;
            MODE_INSERT: state_next = is_full ? S_DONE : S_SCAN;
            MODE_SEARCH: state_next = S_SCAN;
            MODE_READ,
            MODE_REMOVE: state_next = bad_pos ? S_DONE : S_SCAN;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_DONE;
        end else if (left == '0) begin
          state_next = (req_mode == MODE_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    res_push  = (state == S_DONE) && slot_free;
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    case (state)
      S_SCAN: begin
        if (rd_vld) begin
          case (req_mode)
            MODE_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = rd_src + AW'(1);
            end
            MODE_REMOVE: begin
              // first read is the removed entry itself, later ones close up
              ram_we    = (rd_src != req_pos);
              ram_waddr = rd_src - AW'(1);
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      S_WRITE: begin
        ram_we         = 1'b1;
        ram_wdata.id   = req_id;
        ram_wdata.rank = req_rank;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign res.status = res_status;
  assign res.fpos   = res_fpos;
  assign res.id     = res_id;
  assign res.rank   = res_rank;
  assign res.length = 5'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (accept) begin
            req_mode   <= mode_t'(mode);
            req_id     <= entry_id;
            req_rank   <= entry_rank;
            req_pos    <= AW'(position);
            res_status <= STAT_OK;
            res_fpos   <= '0;
            res_id     <= '0;
            res_rank   <= '0;
            case (mode_t'(mode))
              MODE_APPEND: begin
                if (is_full) begin
                  res_status <= STAT_FULL;
                end
                wr_addr <= AW'(count);
              end
              MODE_INSERT: begin
                if (is_full) begin
                  res_status <= STAT_FULL;
                end
                // shift walks downward from the tail
                idx     <= AW'(count - CW'(1));
                left    <= count;
                wr_addr <= '0;
              end
              MODE_SEARCH: begin
                res_status <= STAT_NOT_FOUND;
                idx        <= '0;
                left       <= count;
              end
              MODE_READ: begin
                if (bad_pos) begin
                  res_status <= STAT_BAD_POS;
                end
                idx  <= AW'(position);
                left <= CW'(1);
              end
              MODE_REMOVE: begin
                if (bad_pos) begin
                  res_status <= STAT_BAD_POS;
                end
                idx  <= AW'(position);
                left <= CW'(PW'(count) - PW'(position));
              end
              MODE_CLEAR: count <= '0;
              default: count <= count;
            endcase
          end
        end
        S_SCAN: begin
          if (left != '0) begin
            idx    <= (req_mode == MODE_INSERT) ? idx - AW'(1) : idx + AW'(1);
            left   <= left - CW'(1);
            rd_vld <= 1'b1;
            rd_src <= idx;
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (hit) begin
              res_status <= STAT_OK;
              res_fpos   <= 4'(rd_src);
            end
            if ((req_mode == MODE_READ || req_mode == MODE_REMOVE) && rd_src == req_pos) begin
              res_id   <= ram_rdata.id;
              res_rank <= ram_rdata.rank;
            end
          end
          if (!hit && left == '0 && req_mode == MODE_REMOVE) begin
            count <= count - CW'(1);
          end
        end
        S_WRITE: count <= count + CW'(1);
        default: rd_vld <= 1'b0;
      endcase
    end
  end

endmodule

[src/ordered_list_engine_top.sv]
// ordered_list_engine_top: request intake, result register and entry memory
// depends on olist_pkg, olist_ram and olist_ctrl
//
//  channel   handshake             payload
//  request   in_valid / in_ready   mode, entry_id, entry_rank, position
//  result    out_valid / out_ready status, found_position, out_id, out_rank, list_length
//
// clear, spare modes and refused requests go straight to the result; append writes
// its entry and read fetches one entry first; search, insert and remove walk the entry
// memory one read per cycle, then insert writes; the single read port sets the walk rate
// reset empties the list at once, memory contents are left as they are
// a new request is taken while a finished result waits at the output register
module ordered_list_engine_top import olist_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] entry_id,
  input  logic signed [31:0] entry_rank,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [3:0]         found_position,
  output logic signed [31:0] out_id,
  output logic signed [31:0] out_rank,
  output logic [4:0]         list_length
);

  logic          slot_free;
  logic          res_push;
  result_t       res;
  result_t       res_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign slot_free = !out_valid || out_ready;

  olist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  olist_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .entry_id   (entry_id),
    .entry_rank (entry_rank),
    .position   (position),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q <= res;
    end
  end

  assign status         = res_q.status;
  assign found_position = res_q.fpos;
  assign out_id         = res_q.id;
  assign out_rank       = res_q.rank;
  assign list_length    = res_q.length;

  // a result is only loaded when the output register is free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> slot_free)
    else $error("result loaded over a pending result");

  // a full status is only pushed on a full list
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == STAT_FULL) |-> (res.length == 5'(CAPACITY)))
    else $error("full status with list not full");

  // no new request is taken while a result is being produced
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !in_ready)
    else $error("request accepted while finishing");

endmodule
